### rtl/aho_corasick_matcher_assert.svh
// Assertion macros for the matcher RTL.
// Included by modules that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef AHO_CORASICK_MATCHER_ASSERT_SVH
`define AHO_CORASICK_MATCHER_ASSERT_SVH

// same-cycle implication
`define AC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("matcher check failed");

// next-cycle implication
`define AC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("matcher check failed");

`endif

### rtl/ac_pkg.sv
// Shared constants for the Aho-Corasick matcher: sizes, function and result codes.
// No dependencies.
`timescale 1ns / 1ps

package ac_pkg;
    localparam int MAX_NODES_DEF    = 256;
    localparam int ALPHABET_DEF     = 26;
    localparam int MAX_PATTERNS_DEF = 64;
    localparam int RESULT_CAP       = 64;

    localparam logic [1:0] F_INSERT = 2'd0;
    localparam logic [1:0] F_BUILD  = 2'd1;
    localparam logic [1:0] F_MATCH  = 2'd2;

    localparam logic [2:0] K_OK    = 3'd0;
    localparam logic [2:0] K_FOUND = 3'd1;
    localparam logic [2:0] K_NONE  = 3'd2;
    localparam logic [2:0] K_FULL  = 3'd3;
    localparam logic [2:0] K_PHASE = 3'd4;
endpackage

### rtl/aho_corasick_matcher.sv
// Aho-Corasick matcher top level: sequencer over the goto, node, fail, queue and found memories.
// Depends on ac_pkg, ac_ram and aho_corasick_matcher_assert.svh.
//
// channel | signals                                          | handshake
// input   | i_func, i_symbol, i_ends_pattern, i_starts_text | start & !busy
// result  | o_kind, o_pattern_id, o_last                     | o_valid, one cycle
//
// busy stays high until an accepted item is finished. Phase errors and dropped insert symbols are
// answered from idle; an insert passes S_INS, and S_END on a pattern end. Build scans the
// root's row, then pops each queued node and walks its row. Match steps the goto table, then
// follows the fail chain and checks the found marks at nodes that end a pattern; an invalid
// symbol ends it at once, and a text start first sweeps the found marks. After reset a clearing
// pass holds busy high. Results leave one per cycle at most and cannot be stalled.
`timescale 1ns / 1ps
`include "aho_corasick_matcher_assert.svh"

module aho_corasick_matcher #(
    parameter int MAX_NODES    = ac_pkg::MAX_NODES_DEF,
    parameter int ALPHABET     = ac_pkg::ALPHABET_DEF,
    parameter int MAX_PATTERNS = ac_pkg::MAX_PATTERNS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_func,
    input  logic [4:0] i_symbol,
    input  logic       i_ends_pattern,
    input  logic       i_starts_text,
    output logic       o_valid,
    output logic [2:0] o_kind,
    output logic [5:0] o_pattern_id,
    output logic       o_last
);
    localparam int NW      = $clog2(MAX_NODES);
    localparam int SW      = $clog2(ALPHABET);
    localparam int PW      = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int GAW     = NW + SW;
    localparam int GDEPTH  = MAX_NODES * (1 << SW);
    localparam int CLR_LEN = (GDEPTH > MAX_PATTERNS) ? GDEPTH : MAX_PATTERNS;
    localparam int CW      = $clog2(CLR_LEN + 1);
    localparam int NCW     = $clog2(MAX_NODES + 1);
    localparam int PCW     = $clog2(MAX_PATTERNS + 1);
    localparam int HW      = $clog2(ac_pkg::RESULT_CAP + 1);

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_INS   = 5'd2;
    localparam logic [4:0] S_END   = 5'd3;
    localparam logic [4:0] S_BRR   = 5'd4;
    localparam logic [4:0] S_BRW   = 5'd5;
    localparam logic [4:0] S_BPOP  = 5'd6;
    localparam logic [4:0] S_BPOPW = 5'd7;
    localparam logic [4:0] S_BF    = 5'd8;
    localparam logic [4:0] S_BCR   = 5'd9;
    localparam logic [4:0] S_BCW   = 5'd10;
    localparam logic [4:0] S_FCLR  = 5'd11;
    localparam logic [4:0] S_MSTEP = 5'd12;
    localparam logic [4:0] S_MG    = 5'd13;
    localparam logic [4:0] S_MK    = 5'd14;
    localparam logic [4:0] S_MKW   = 5'd15;
    localparam logic [4:0] S_MFW   = 5'd16;

    logic [4:0]     r_state, n_state;
    logic [CW-1:0]  r_clr, n_clr;
    logic [4:0]     r_sym, n_sym;
    logic           r_end, n_end;
    logic [NCW-1:0] r_nodes, n_nodes;
    logic [PCW-1:0] r_pats, n_pats;
    logic [NW-1:0]  r_icur, n_icur;
    logic [NW-1:0]  r_mcur, n_mcur;
    logic           r_ovf, n_ovf;
    logic           r_built, n_built;
    logic [SW-1:0]  r_c, n_c;
    logic [NCW-1:0] r_head, n_head;
    logic [NCW-1:0] r_tail, n_tail;
    logic [NW-1:0]  r_now, n_now;
    logic [NW-1:0]  r_f, n_f;
    logic [NW-1:0]  r_k, n_k;
    logic [NCW-1:0] r_steps, n_steps;
    logic [HW-1:0]  r_hits, n_hits;
    logic           r_pend_v, n_pend_v;
    logic [PW-1:0]  r_pend_p, n_pend_p;
    logic [PW-1:0]  r_p, n_p;
    logic [PCW-1:0] r_fcnt, n_fcnt;
    logic           r_valid, n_valid;
    logic [2:0]     r_kind, n_kind;
    logic [PW-1:0]  r_pid, n_pid;
    logic           r_last, n_last;

    logic           g_we;
    logic [GAW-1:0] g_waddr, g_raddr_a, g_raddr_b;
    logic [NW-1:0]  g_wdata, g_rd_a, g_rd_b;
    logic           nd_we;
    logic [NW-1:0]  nd_waddr, nd_raddr;
    logic [PW:0]    nd_wdata, nd_rd, nd_rd_b;
    logic           fl_we;
    logic [NW-1:0]  fl_waddr, fl_wdata, fl_raddr, fl_rd, fl_rd_b;
    logic           q_we;
    logic [NW-1:0]  q_waddr, q_wdata, q_raddr, q_rd, q_rd_b;
    logic           fd_we;
    logic [PW-1:0]  fd_waddr, fd_raddr;
    logic           fd_wdata, fd_rd, fd_rd_b;

    logic [SW+4:0]  i_sx, r_sx;
    logic           i_sym_ok, r_sym_ok;
    logic [NW-1:0]  ins_nxt;
    logic           ins_ovf;
    logic           tail_ok;
    logic [PW+5:0]  pid_ext;

    assign i_sx     = {{SW{1'b0}}, i_symbol};
    assign r_sx     = {{SW{1'b0}}, r_sym};
    assign i_sym_ok = (32'(i_symbol) < ALPHABET);
    assign r_sym_ok = (32'(r_sym) < ALPHABET);
    assign tail_ok  = (r_tail < NCW'(MAX_NODES));

    always_comb begin
        ins_nxt = g_rd_a;
        ins_ovf = 1'b0;
        if (g_rd_a == '0) begin
            if (r_nodes < NCW'(MAX_NODES)) begin
                ins_nxt = r_nodes[NW-1:0];
            end else begin
                ins_ovf = 1'b1;
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_sym    = r_sym;
        n_end    = r_end;
        n_nodes  = r_nodes;
        n_pats   = r_pats;
        n_icur   = r_icur;
        n_mcur   = r_mcur;
        n_ovf    = r_ovf;
        n_built  = r_built;
        n_c      = r_c;
        n_head   = r_head;
        n_tail   = r_tail;
        n_now    = r_now;
        n_f      = r_f;
        n_k      = r_k;
        n_steps  = r_steps;
        n_hits   = r_hits;
        n_pend_v = r_pend_v;
        n_pend_p = r_pend_p;
        n_p      = r_p;
        n_fcnt   = r_fcnt;
        n_valid  = 1'b0;
        n_kind   = ac_pkg::K_OK;
        n_pid    = '0;
        n_last   = 1'b1;

        g_we      = 1'b0;
        g_waddr   = {r_now, r_c};
        g_wdata   = g_rd_b;
        g_raddr_a = {r_now, r_c};
        g_raddr_b = {r_f, r_c};
        nd_we     = 1'b0;
        nd_waddr  = r_icur;
        nd_wdata  = {1'b1, r_pats[PW-1:0]};
        nd_raddr  = r_k;
        fl_we     = 1'b0;
        fl_waddr  = g_rd_a;
        fl_wdata  = g_rd_b;
        fl_raddr  = r_k;
        q_we      = 1'b0;
        q_waddr   = r_tail[NW-1:0];
        q_wdata   = g_rd_a;
        q_raddr   = r_head[NW-1:0];
        fd_we     = 1'b0;
        fd_waddr  = r_p;
        fd_wdata  = 1'b1;
        fd_raddr  = nd_rd[PW-1:0];

        unique case (r_state)
            S_CLEAR: begin
                g_we     = 1'b1;
                g_waddr  = r_clr[GAW-1:0];
                g_wdata  = '0;
                nd_we    = 1'b1;
                nd_waddr = r_clr[NW-1:0];
                nd_wdata = '0;
                fd_we    = 1'b1;
                fd_waddr = r_clr[PW-1:0];
                fd_wdata = 1'b0;
                n_clr    = r_clr + 1'b1;
                if (r_clr == CW'(CLR_LEN - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                g_raddr_a = {r_icur, i_sx[SW-1:0]};
                if (start) begin
                    n_sym = i_symbol;
                    n_end = i_ends_pattern;
                    unique case (i_func)
                        ac_pkg::F_INSERT: begin
                            if (r_built) begin
                                n_valid = 1'b1;
                                n_kind  = ac_pkg::K_PHASE;
                            end else if (r_ovf || !i_sym_ok) begin
                                n_valid = 1'b1;
                                n_kind  = r_ovf ? ac_pkg::K_FULL : ac_pkg::K_PHASE;
                                n_ovf   = !i_ends_pattern;
                                if (i_ends_pattern) begin
                                    n_icur = '0;
                                end
                            end else begin
                                n_state = S_INS;
                            end
                        end
                        ac_pkg::F_BUILD: begin
                            if (r_built) begin
                                n_valid = 1'b1;
                                n_kind  = ac_pkg::K_PHASE;
                            end else begin
                                n_icur  = '0;
                                n_ovf   = 1'b0;
                                n_c     = '0;
                                n_head  = '0;
                                n_tail  = '0;
                                n_state = S_BRR;
                            end
                        end
                        ac_pkg::F_MATCH: begin
                            if (!r_built) begin
                                n_valid = 1'b1;
                                n_kind  = ac_pkg::K_PHASE;
                            end else if (i_starts_text) begin
                                n_mcur  = '0;
                                n_fcnt  = '0;
                                n_state = S_FCLR;
                            end else begin
                                n_state = S_MSTEP;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                            n_kind  = ac_pkg::K_PHASE;
                        end
                    endcase
                end
            end
            S_INS: begin
                nd_raddr = ins_nxt;
                if (g_rd_a == '0 && !ins_ovf) begin
                    g_we    = 1'b1;
                    g_waddr = {r_icur, r_sx[SW-1:0]};
                    g_wdata = ins_nxt;
                    n_nodes = r_nodes + 1'b1;
                end
                if (ins_ovf) begin
                    n_valid = 1'b1;
                    n_kind  = ac_pkg::K_FULL;
                    n_ovf   = !r_end;
                    n_state = S_IDLE;
                    if (r_end) begin
                        n_icur = '0;
                    end
                end else if (r_end) begin
                    n_icur  = ins_nxt;
                    n_state = S_END;
                end else begin
                    n_icur  = ins_nxt;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_END: begin
                n_valid = 1'b1;
                if (nd_rd[PW]) begin
                    n_pid = nd_rd[PW-1:0];
                end else if (r_pats < PCW'(MAX_PATTERNS)) begin
                    nd_we  = 1'b1;
                    n_pid  = r_pats[PW-1:0];
                    n_pats = r_pats + 1'b1;
                end else begin
                    n_kind = ac_pkg::K_FULL;
                end
                n_icur  = '0;
                n_ovf   = 1'b0;
                n_state = S_IDLE;
            end
            S_BRR: begin
                g_raddr_a = {{NW{1'b0}}, r_c};
                n_state   = S_BRW;
            end
            S_BRW: begin
                if (g_rd_a != '0) begin
                    fl_we   = 1'b1;
                    fl_wdata = '0;
                    if (tail_ok) begin
                        q_we   = 1'b1;
                        n_tail = r_tail + 1'b1;
                    end
                end
                n_c = r_c + 1'b1;
                n_state = (r_c == SW'(ALPHABET - 1)) ? S_BPOP : S_BRR;
            end
            S_BPOP: begin
                if (r_head < r_tail) begin
                    n_state = S_BPOPW;
                end else begin
                    n_built = 1'b1;
                    n_mcur  = '0;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_BPOPW: begin
                fl_raddr = q_rd;
                n_now    = q_rd;
                n_head   = r_head + 1'b1;
                n_state  = S_BF;
            end
            S_BF: begin
                n_f     = fl_rd;
                n_c     = '0;
                n_state = S_BCR;
            end
            S_BCR: begin
                n_state = S_BCW;
            end
            S_BCW: begin
                if (g_rd_a == '0) begin
                    g_we = 1'b1;
                end else begin
                    fl_we = 1'b1;
                    if (tail_ok) begin
                        q_we   = 1'b1;
                        n_tail = r_tail + 1'b1;
                    end
                end
                n_c = r_c + 1'b1;
                n_state = (r_c == SW'(ALPHABET - 1)) ? S_BPOP : S_BCR;
            end
            S_FCLR: begin
                fd_we    = 1'b1;
                fd_waddr = r_fcnt[PW-1:0];
                fd_wdata = 1'b0;
                n_fcnt   = r_fcnt + 1'b1;
                if (r_fcnt == PCW'(MAX_PATTERNS - 1)) begin
                    n_state = S_MSTEP;
                end
            end
            S_MSTEP: begin
                g_raddr_a = {r_mcur, r_sx[SW-1:0]};
                if (!r_sym_ok) begin
                    n_mcur  = '0;
                    n_valid = 1'b1;
                    n_kind  = ac_pkg::K_NONE;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_MG;
                end
            end
            S_MG: begin
                n_mcur   = g_rd_a;
                n_k      = g_rd_a;
                n_steps  = '0;
                n_hits   = '0;
                n_pend_v = 1'b0;
                n_state  = S_MK;
            end
            S_MK: begin
                if (r_k == '0 || r_steps == NCW'(MAX_NODES)
                        || r_hits == HW'(ac_pkg::RESULT_CAP)) begin
                    n_valid = 1'b1;
                    n_kind  = r_pend_v ? ac_pkg::K_FOUND : ac_pkg::K_NONE;
                    n_pid   = r_pend_v ? r_pend_p : '0;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_MKW;
                end
            end
            S_MKW: begin
                n_k     = fl_rd;
                n_steps = r_steps + 1'b1;
                if (nd_rd[PW] && (PCW'(nd_rd[PW-1:0]) < PCW'(MAX_PATTERNS))) begin
                    n_p     = nd_rd[PW-1:0];
                    n_state = S_MFW;
                end else begin
                    n_state = S_MK;
                end
            end
            S_MFW: begin
                if (!fd_rd) begin
                    fd_we  = 1'b1;
                    n_hits = r_hits + 1'b1;
                    if (r_pend_v) begin
                        n_valid = 1'b1;
                        n_kind  = ac_pkg::K_FOUND;
                        n_pid   = r_pend_p;
                        n_last  = 1'b0;
                    end
                    n_pend_v = 1'b1;
                    n_pend_p = r_p;
                end
                n_state = S_MK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_nodes  <= NCW'(1);
            r_pats   <= '0;
            r_icur   <= '0;
            r_mcur   <= '0;
            r_ovf    <= 1'b0;
            r_built  <= 1'b0;
            r_c      <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_steps  <= '0;
            r_hits   <= '0;
            r_pend_v <= 1'b0;
            r_fcnt   <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_nodes  <= n_nodes;
            r_pats   <= n_pats;
            r_icur   <= n_icur;
            r_mcur   <= n_mcur;
            r_ovf    <= n_ovf;
            r_built  <= n_built;
            r_c      <= n_c;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_steps  <= n_steps;
            r_hits   <= n_hits;
            r_pend_v <= n_pend_v;
            r_fcnt   <= n_fcnt;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym    <= n_sym;
        r_end    <= n_end;
        r_now    <= n_now;
        r_f      <= n_f;
        r_k      <= n_k;
        r_pend_p <= n_pend_p;
        r_p      <= n_p;
        r_kind   <= n_kind;
        r_pid    <= n_pid;
        r_last   <= n_last;
    end

    ac_ram #(.DEPTH(GDEPTH), .AW(GAW), .DW(NW)) u_goto (
        .i_clk(i_clk), .i_we(g_we), .i_waddr(g_waddr), .i_wdata(g_wdata),
        .i_raddr_a(g_raddr_a), .o_rdata_a(g_rd_a),
        .i_raddr_b(g_raddr_b), .o_rdata_b(g_rd_b)
    );

    ac_ram #(.DEPTH(MAX_NODES), .AW(NW), .DW(PW + 1)) u_node (
        .i_clk(i_clk), .i_we(nd_we), .i_waddr(nd_waddr), .i_wdata(nd_wdata),
        .i_raddr_a(nd_raddr), .o_rdata_a(nd_rd),
        .i_raddr_b(nd_raddr), .o_rdata_b(nd_rd_b)
    );

    ac_ram #(.DEPTH(MAX_NODES), .AW(NW), .DW(NW)) u_fail (
        .i_clk(i_clk), .i_we(fl_we), .i_waddr(fl_waddr), .i_wdata(fl_wdata),
        .i_raddr_a(fl_raddr), .o_rdata_a(fl_rd),
        .i_raddr_b(fl_raddr), .o_rdata_b(fl_rd_b)
    );

    ac_ram #(.DEPTH(MAX_NODES), .AW(NW), .DW(NW)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr_a(q_raddr), .o_rdata_a(q_rd),
        .i_raddr_b(q_raddr), .o_rdata_b(q_rd_b)
    );

    ac_ram #(.DEPTH(MAX_PATTERNS), .AW(PW), .DW(1)) u_found (
        .i_clk(i_clk), .i_we(fd_we), .i_waddr(fd_waddr), .i_wdata(fd_wdata),
        .i_raddr_a(fd_raddr), .o_rdata_a(fd_rd),
        .i_raddr_b(fd_raddr), .o_rdata_b(fd_rd_b)
    );

    assign pid_ext      = {6'b0, r_pid};
    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_pattern_id = pid_ext[5:0];
    assign o_last       = r_last;

    `AC_ASSERT_NOW(a_found_after_build, o_valid && o_kind == ac_pkg::K_FOUND, r_built)
    `AC_ASSERT_NOW(a_early_needs_more, o_valid && !o_last,
        o_kind == ac_pkg::K_FOUND && r_state != S_IDLE)
    `AC_ASSERT_NEXT(a_build_starts, start && !busy && i_func == ac_pkg::F_BUILD && !r_built,
        r_state == S_BRR)
    `AC_ASSERT_NOW(a_nodes_bound, 1'b1,
        r_nodes != '0 && r_nodes <= NCW'(MAX_NODES))
endmodule

### rtl/ac_ram.sv
// Simple dual-read memory: one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps

module ac_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    output logic [DW-1:0] o_rdata_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_b
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_a;
    logic [DW-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;
endmodule
